// ===== rtl/sgow_pkg.sv =====
package sgow_pkg;

    // build constants
    localparam int SAMPLE_BITS = 10;
    localparam int WINDOW_MAX  = 4096;

    // field widths
    localparam int RAW_W    = 10;
    localparam int SCALE_W  = 24;
    localparam int GAIN_W   = 15;
    localparam int OFFSET_W = 13;
    localparam int LEN_W    = 13;
    localparam int VAL_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // derived datapath widths
    localparam int MV_W   = SAMPLE_BITS + SCALE_W - 16;
    localparam int PROD_W = MV_W + SCALE_W;
    localparam int G_W    = MV_W + GAIN_W - 14;
    localparam int V_W    = (G_W > 17) ? G_W + 1 : 18;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = VAL_W + $clog2(WINDOW_MAX) + 1;
    localparam int STEP_W = $clog2(SUM_W + 1);

    // gain clip level, well above anything the offset can pull back into range
    localparam int G_CLIP = 40000;

    // register reset values
    localparam logic [SCALE_W-1:0]         SCALE_RESET  = 24'd211406;
    localparam logic [GAIN_W-1:0]          GAIN_RESET   = 15'd16384;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = '0;
    localparam logic [LEN_W-1:0]           LEN_RESET    = 13'd100;

    // register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_CODE_SCALE = 4'd0;
    localparam t_cfg_idx REG_GAIN       = 4'd1;
    localparam t_cfg_idx REG_OFFSET     = 4'd2;
    localparam t_cfg_idx REG_WINDOW_LEN = 4'd3;

    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [VAL_W-1:0]  t_val;

endpackage

// ===== rtl/sgow_div.sv =====
module sgow_div
    import sgow_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sum i_dividend,
    input  t_cnt i_divisor,
    output logic o_done,
    output t_val o_quotient
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_neg, n_neg;
    logic [SUM_W-1:0]  r_quo, n_quo;
    t_cnt              r_rem, n_rem;
    t_cnt              r_div, n_div;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic [SUM_W-1:0]  magnitude;
    logic [SUM_W-1:0]  signed_quo;

    // one restoring step per cycle on the magnitudes
    always_comb begin
        magnitude = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
        trial     = {r_rem, r_quo[SUM_W-1]};
        diff      = trial - {1'b0, r_div};
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_step    = r_step;
        n_neg     = r_neg;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div     = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_neg  = i_dividend[SUM_W-1];
            n_quo  = magnitude;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = diff[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_neg <= n_neg;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    // truncation toward zero: negate the magnitude quotient for a negative sum
    assign signed_quo = r_neg ? -r_quo : r_quo;
    assign o_quotient = t_val'(signed_quo[VAL_W-1:0]);
    assign o_done     = r_done;

endmodule

// ===== rtl/sample_gain_offset_window_stats_unit.sv =====
// Conditions one converter code per word: code times a Q16 millivolt scale, times a Q14
// gain, plus a signed millivolt offset, saturated to 16 bits signed. Every input word
// yields one output word with the conditioned value; the word that fills the window of
// window_len samples (0 acts as 1, values above 4096 act as 4096) also carries the window
// mean (truncated toward zero), minimum and maximum, and the window restarts. One shared
// multiplier runs twice per word; an ordinary word passes the states S_MUL1, S_MUL2, S_SAT,
// S_ACC and S_OUT before output valid, and a window-closing word also waits in S_DIV for a
// bit-serial divider of 29 steps. The input is not ready while a word is in work. Configuration writes
// (index 0 scale, 1 gain, 2 offset, 3 window length, others ignored) are always accepted
// and belong in idle periods.
module sample_gain_offset_window_stats_unit
    import sgow_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [RAW_W-1:0]      i_raw_code,
    // output words
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [VAL_W-1:0] o_value_mv,
    output logic                  o_window_done,
    output logic signed [VAL_W-1:0] o_window_mean,
    output logic signed [VAL_W-1:0] o_window_min,
    output logic signed [VAL_W-1:0] o_window_max,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_SAT  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [SCALE_W-1:0]         r_scale;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [OFFSET_W-1:0] r_offset;
    logic [LEN_W-1:0]           r_window_len;

    // datapath
    logic [SAMPLE_BITS-1:0] r_code;
    logic [PROD_W-1:0]      r_prod, n_prod;
    t_val                   r_value, n_value;

    // window state
    t_sum r_sum, n_sum;
    t_val r_min, n_min;
    t_val r_max, n_max;
    t_cnt r_count, n_count;

    // pending result
    logic r_res_done, n_res_done;
    t_val r_res_mean, n_res_mean;
    t_val r_res_min, n_res_min;
    t_val r_res_max, n_res_max;

    // output register
    logic r_out_valid, n_out_valid;
    t_val r_out_value;
    logic r_out_done;
    t_val r_out_mean;
    t_val r_out_min;
    t_val r_out_max;
    logic load_out;

    // shared multiplier operands
    logic [MV_W-1:0]    mul_a;
    logic [SCALE_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;

    logic [G_W-1:0]        g_raw;
    logic [G_W-1:0]        g_clip;
    logic signed [V_W-1:0] v_sum;

    t_cnt eff_len;
    t_cnt count_inc;
    t_sum v_ext;
    t_sum sum_acc;
    t_val min_acc;
    t_val max_acc;
    logic close_win;

    logic div_start;
    logic div_done;
    t_val div_quo;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_RESET;
            r_gain       <= GAIN_RESET;
            r_offset     <= OFFSET_RESET;
            r_window_len <= LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CODE_SCALE: r_scale      <= i_cfg_data[SCALE_W-1:0];
                REG_GAIN:       r_gain       <= i_cfg_data[GAIN_W-1:0];
                REG_OFFSET:     r_offset     <= i_cfg_data[OFFSET_W-1:0];
                REG_WINDOW_LEN: r_window_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // multiplier operand select: code by scale, then millivolts by gain
    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = MV_W'(r_code);
            mul_b = r_scale;
        end else begin
            mul_a = r_prod[16 +: MV_W];
            mul_b = SCALE_W'(r_gain);
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // clip, offset and saturate
    always_comb begin
        g_raw  = r_prod[14 +: G_W];
        g_clip = (int'(g_raw) > G_CLIP) ? G_W'(G_CLIP) : g_raw;
        v_sum  = $signed(V_W'(g_clip)) + V_W'(r_offset);
        if (v_sum > V_W'(32767)) begin
            n_value = t_val'(16'sd32767);
        end else if (v_sum < -$signed(V_W'(32768))) begin
            n_value = t_val'(-16'sd32768);
        end else begin
            n_value = v_sum[VAL_W-1:0];
        end
    end

    // effective window length and running statistics
    always_comb begin
        if (r_window_len == '0) begin
            eff_len = t_cnt'(1);
        end else if (int'(r_window_len) > WINDOW_MAX) begin
            eff_len = t_cnt'(WINDOW_MAX);
        end else begin
            eff_len = t_cnt'(r_window_len);
        end
        v_ext     = SUM_W'(r_value);
        count_inc = r_count + 1'b1;
        if (r_count == '0) begin
            sum_acc = v_ext;
            min_acc = r_value;
            max_acc = r_value;
        end else begin
            sum_acc = r_sum + v_ext;
            min_acc = (r_value < r_min) ? r_value : r_min;
            max_acc = (r_value > r_max) ? r_value : r_max;
        end
        close_win = (count_inc >= eff_len);
    end

    assign load_out  = !r_out_valid || i_ready;
    assign div_start = (r_state == S_ACC) && close_win;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_count     = r_count;
        n_res_done  = r_res_done;
        n_res_mean  = r_res_mean;
        n_res_min   = r_res_min;
        n_res_max   = r_res_max;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_prod  = mul_p;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_prod  = mul_p;
                n_state = S_SAT;
            end
            S_SAT: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (close_win) begin
                    n_res_done = 1'b1;
                    n_res_min  = min_acc;
                    n_res_max  = max_acc;
                    n_sum      = '0;
                    n_min      = '0;
                    n_max      = '0;
                    n_count    = '0;
                    n_state    = S_DIV;
                end else begin
                    n_res_done = 1'b0;
                    n_res_mean = '0;
                    n_res_min  = '0;
                    n_res_max  = '0;
                    n_sum      = sum_acc;
                    n_min      = min_acc;
                    n_max      = max_acc;
                    n_count    = count_inc;
                    n_state    = S_OUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res_mean = div_quo;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
            r_count     <= n_count;
        end
        if (r_state == S_IDLE && i_valid) begin
            r_code <= SAMPLE_BITS'(i_raw_code);
        end
        if (r_state == S_SAT) begin
            r_value <= n_value;
        end
        r_prod     <= n_prod;
        r_res_done <= n_res_done;
        r_res_mean <= n_res_mean;
        r_res_min  <= n_res_min;
        r_res_max  <= n_res_max;
        if (r_state == S_OUT && load_out) begin
            r_out_value <= r_value;
            r_out_done  <= r_res_done;
            r_out_mean  <= r_res_mean;
            r_out_min   <= r_res_min;
            r_out_max   <= r_res_max;
        end
    end

    // window mean divider
    sgow_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_acc),
        .i_divisor  (count_inc),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_value_mv    = r_out_value;
    assign o_window_done = r_out_done;
    assign o_window_mean = r_out_mean;
    assign o_window_min  = r_out_min;
    assign o_window_max  = r_out_max;

endmodule

// ===== tb/sample_gain_offset_window_stats_unit_tb.sv =====
module sample_gain_offset_window_stats_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgow_pkg::*;

    localparam int CLOSE_LATENCY    = 64;
    localparam int HOLD_CYCLES      = 300;
    localparam int RUN_LIMIT        = 2_000_000;
    localparam int PHASE_ITEMS      = 200;
    localparam int RAND_PHASES      = 8;
    localparam int BIG_WINDOW_ITEMS = 150;
    localparam int NUM_REGS         = REG_WINDOW_LEN + 1;
    localparam longint VAL_HI       = 2 ** (VAL_W - 1) - 1;
    localparam longint VAL_LO       = -(2 ** (VAL_W - 1));

    // idle percentages per phase kind: none, sender, receiver, both
    localparam int IDLE_MODES[4]  = '{0, 50, 0, 17};
    localparam int STALL_MODES[4] = '{0, 0, 50, 17};

    typedef struct {
        t_val value;
        logic done;
        t_val mean;
        t_val lo;
        t_val hi;
    } t_stats_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [RAW_W-1:0]      i_raw_code = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_val                  o_value_mv;
    logic                  o_window_done;
    t_val                  o_window_mean;
    t_val                  o_window_min;
    t_val                  o_window_max;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = REG_CODE_SCALE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [RAW_W-1:0] pending_codes[$];
    t_stats_word      expected_words[$];
    int               idle_pct = 0;
    int               stall_pct = 0;
    int               error_count = 0;
    logic             rx_hold = 1'b0;
    event             hold_off_rx;

    // conditioning settings and open window as the block should hold them
    logic [SCALE_W-1:0]         cond_scale = SCALE_RESET;
    logic [GAIN_W-1:0]          cond_gain = GAIN_RESET;
    logic signed [OFFSET_W-1:0] cond_offset = OFFSET_RESET;
    logic [LEN_W-1:0]           win_len = LEN_RESET;
    t_sum                       win_sum = '0;
    t_val                       win_min = '0;
    t_val                       win_max = '0;
    t_cnt                       win_count = '0;

    sample_gain_offset_window_stats_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_raw_code    (i_raw_code),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_value_mv    (o_value_mv),
        .o_window_done (o_window_done),
        .o_window_mean (o_window_mean),
        .o_window_min  (o_window_min),
        .o_window_max  (o_window_max),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // code to millivolts, gain and its clip, offset, then clamp to the output range
    function automatic t_val condition_code(logic [RAW_W-1:0] code);
        logic [63:0] mv;
        logic [63:0] g;
        longint      v;
        mv = (64'(code) * 64'(cond_scale)) >> 16;
        g  = (mv * 64'(cond_gain)) >> 14;
        if (g > 64'(G_CLIP))
            g = 64'(G_CLIP);
        v = longint'(g) + longint'(cond_offset);
        if (v > VAL_HI)
            v = VAL_HI;
        if (v < VAL_LO)
            v = VAL_LO;
        return t_val'(v);
    endfunction

    // fold one sample into the open window and queue the word it yields
    task automatic window_stats_step(logic [RAW_W-1:0] code);
        t_stats_word w;
        t_val        v;
        t_cnt        len;
        v = condition_code(code);
        if (win_len == '0)
            len = t_cnt'(1);
        else if (win_len > WINDOW_MAX)
            len = t_cnt'(WINDOW_MAX);
        else
            len = t_cnt'(win_len);
        if (win_count == '0) begin
            win_sum = t_sum'(v);
            win_min = v;
            win_max = v;
        end else begin
            win_sum = win_sum + t_sum'(v);
            if (v < win_min)
                win_min = v;
            if (v > win_max)
                win_max = v;
        end
        win_count = win_count + 1'b1;
        w = '{value: v, done: 1'b0, mean: '0, lo: '0, hi: '0};
        if (win_count >= len) begin
            w.done    = 1'b1;
            w.mean    = t_val'(longint'(win_sum) / longint'(win_count));
            w.lo      = win_min;
            w.hi      = win_max;
            win_sum   = '0;
            win_min   = '0;
            win_max   = '0;
            win_count = '0;
        end
        expected_words.push_back(w);
    endtask

    task automatic apply_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CODE_SCALE: cond_scale  = data[SCALE_W-1:0];
            REG_GAIN:       cond_gain   = data[GAIN_W-1:0];
            REG_OFFSET:     cond_offset = data[OFFSET_W-1:0];
            REG_WINDOW_LEN: win_len     = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic void check_field(string what, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            error_count++;
        end
    endfunction

    // input driver, fed from the pending code queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_codes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_valid    <= 1'b1;
                i_raw_code <= pending_codes.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output ready, random stalls plus the long hold-off
    always @(posedge i_clk) begin
        if (rx_hold)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always begin
        @(hold_off_rx);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // monitor: check output words, predict accepted samples, track register writes
    always @(posedge i_clk) begin : monitor
        t_stats_word w;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word expected none actual value %0d",
                             $time, o_value_mv);
                    error_count++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("value_mv", w.value, o_value_mv);
                    check_field("window_done", w.done, o_window_done);
                    check_field("window_mean", w.mean, o_window_mean);
                    check_field("window_min", w.lo, o_window_min);
                    check_field("window_max", w.hi, o_window_max);
                end
            end
            if (i_valid && o_ready)
                window_stats_step(i_raw_code);
            if (i_cfg_valid && o_cfg_ready)
                apply_register(i_cfg_index, i_cfg_data);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every word is back and the block has gone quiet
    task automatic drain();
        do @(posedge i_clk);
        while (pending_codes.size() != 0 || i_valid || expected_words.size() != 0);
        repeat (CLOSE_LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [RAW_W-1:0] random_code();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    task automatic randomize_registers();
        int                    first;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        logic [LEN_W-1:0]      len;
        first = $urandom_range(NUM_REGS - 1);
        for (int j = 0; j < NUM_REGS; j++) begin
            idx = t_cfg_idx'((first + j) % NUM_REGS);
            case (idx)
                REG_CODE_SCALE: begin
                    case ($urandom_range(3))
                        0, 1:    data = CFG_DATA_W'($urandom_range(100000, 400000));
                        2:       data = CFG_DATA_W'($urandom);
                        default: data = CFG_DATA_W'($urandom_range(4095));
                    endcase
                end
                REG_WINDOW_LEN: begin
                    case ($urandom_range(9))
                        0:       len = '0;
                        1, 2:    len = LEN_W'($urandom_range(17, 120));
                        default: len = LEN_W'($urandom_range(1, 16));
                    endcase
                    data = CFG_DATA_W'(($urandom << LEN_W) | len);
                end
                default: data = CFG_DATA_W'($urandom);
            endcase
            write_reg(idx, data);
        end
        // writes past the register list must change nothing
        if ($urandom_range(3) == 0)
            write_reg(t_cfg_idx'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, code extremes and alternating bits
        pending_codes = '{10'd0, 10'd1023, 10'd1, 10'd512, 10'h155, 10'h2AA};
        drain();

        // window length zero, full scale and gain, top offset: saturation high
        write_reg(REG_WINDOW_LEN, 24'hFFE000);
        write_reg(REG_CODE_SCALE, '1);
        write_reg(REG_GAIN, 24'hFF7FFF);
        write_reg(REG_OFFSET, 24'hABCFFF);
        pending_codes = '{10'd0, 10'd1, 10'd1023, 10'd700};
        drain();

        // zero scale and gain with the most negative offset
        write_reg(REG_CODE_SCALE, '0);
        write_reg(REG_GAIN, '0);
        write_reg(REG_OFFSET, 24'h001000);
        pending_codes = '{10'd1023, 10'd0};
        drain();

        // unlisted indexes, then a long window cut short below its count
        write_reg(t_cfg_idx'(NUM_REGS), '1);
        write_reg(t_cfg_idx'((1 << CFG_IDX_W) - 1), '1);
        write_reg(REG_CODE_SCALE, CFG_DATA_W'(SCALE_RESET));
        write_reg(REG_GAIN, CFG_DATA_W'(GAIN_RESET));
        write_reg(REG_OFFSET, 24'h001FFF);
        write_reg(REG_WINDOW_LEN, 24'h001000);
        for (int k = 0; k < 8; k++)
            pending_codes.push_back(random_code());
        drain();
        write_reg(REG_WINDOW_LEN, 24'h000003);
        pending_codes = '{10'd300, 10'd900};
        drain();

        // oversized window length: the window stays open into the next phase
        write_reg(REG_WINDOW_LEN, '1);
        write_reg(REG_CODE_SCALE, '1);
        write_reg(REG_GAIN, CFG_DATA_W'($urandom));
        write_reg(REG_OFFSET, CFG_DATA_W'($urandom));
        for (int k = 0; k < BIG_WINDOW_ITEMS; k++)
            pending_codes.push_back(random_code());
        drain();

        // random phases over all idle kinds
        for (int p = 0; p < RAND_PHASES; p++) begin
            idle_pct  = IDLE_MODES[p % 4];
            stall_pct = STALL_MODES[p % 4];
            randomize_registers();
            for (int k = 0; k < PHASE_ITEMS; k++)
                pending_codes.push_back(random_code());
            if (p == 1 || p == 4)
                -> hold_off_rx;
            drain();
        end

        if (error_count == 0)
            $display("sample_gain_offset_window_stats_unit_tb: clean");
        else
            $display("sample_gain_offset_window_stats_unit_tb: errors");
        $finish;
    end

    // run limit
    initial begin : watchdog
        for (int n = 0; n < RUN_LIMIT; n++)
            @(posedge i_clk);
        $display("sample_gain_offset_window_stats_unit_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sgow_pkg.sv
rtl/sgow_div.sv
rtl/sample_gain_offset_window_stats_unit.sv
tb/sample_gain_offset_window_stats_unit_tb.sv
